// ----- sv/tge_pkg.sv -----
// Shared types and constants of the touch gesture engine.
// Used by tge_scale and touch_gesture_engine. It depends on nothing else.
package tge_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned DeltaBits = CoordBits + 1;
  localparam int unsigned RemBits   = 17;
  localparam int unsigned ProdBits  = DeltaBits + 17;
  localparam int unsigned VBits     = ProdBits + 1;
  localparam int unsigned MagBits   = CoordBits + 16;
  localparam int unsigned CntBits   = $clog2(MagBits);

  localparam logic [3:0] IdInvalid = 4'hF;
  localparam logic [3:0] MaxCount  = 4'd2;

  typedef enum logic [2:0] {
    EVT_MOVE_X = 3'd0,
    EVT_MOVE_Y = 3'd1,
    EVT_HWHEEL = 3'd2,
    EVT_WHEEL  = 3'd3,
    EVT_BUTTON = 3'd4
  } evt_e;

  typedef enum logic [2:0] {
    CFG_MOVE_GAIN    = 3'd0,
    CFG_MOVE_DIVIDE  = 3'd1,
    CFG_WHEEL_DIVIDE = 3'd2,
    CFG_TAP_WINDOW   = 3'd3,
    CFG_TAP_SLACK    = 3'd4,
    CFG_SCROLL_SLACK = 3'd5,
    CFG_CLICK_HOLD   = 3'd6,
    CFG_FLIP_X       = 3'd7
  } cfg_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_POINTER,
    MODE_SCROLL,
    MODE_WAIT
  } mode_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DECODE,
    SEQ_X_GO,
    SEQ_X_WAIT,
    SEQ_Y_GO,
    SEQ_Y_WAIT,
    SEQ_PAIR,
    SEQ_EMIT
  } seq_e;

  typedef enum logic [2:0] {
    SCL_IDLE,
    SCL_MUL,
    SCL_ADD,
    SCL_DIV,
    SCL_DONE
  } scl_e;

  typedef struct packed {
    logic                 req_type;
    logic [3:0]           raw_count;
    logic [3:0]           first_id;
    logic [CoordBits-1:0] first_raw_x;
    logic [CoordBits-1:0] first_raw_y;
    logic [3:0]           second_id;
    logic [CoordBits-1:0] second_raw_x;
    logic [CoordBits-1:0] second_raw_y;
  } in_t;

  typedef struct packed {
    logic [2:0]         event_code;
    logic               button_id;
    logic signed [15:0] event_value;
    logic               sync_flag;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic                        start;
    logic signed [DeltaBits-1:0] delta;
    logic [15:0]                 gain;
    logic [15:0]                 divisor;
    logic signed [RemBits-1:0]   rem;
  } scl_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [15:0]        quot;
    logic signed [RemBits-1:0] rem;
  } scl_rsp_t;

endpackage

// ----- sv/tge_scale.sv -----
// Shared scaling unit: multiply, add the kept remainder, then a serial restoring divide.
// Depends on tge_pkg.
module tge_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tge_pkg::scl_req_t  req_i,
  output tge_pkg::scl_rsp_t  rsp_o
);

  tge_pkg::scl_e scl_q, scl_d;

  logic signed [tge_pkg::DeltaBits-1:0] delta_q, delta_d;
  logic [15:0]                          gain_q, gain_d;
  logic [15:0]                          div_q, div_d;
  logic signed [tge_pkg::RemBits-1:0]   rin_q, rin_d;
  logic signed [tge_pkg::ProdBits-1:0]  prod_q, prod_d;
  logic                                 neg_q, neg_d;
  logic [tge_pkg::MagBits-1:0]          mag_q, mag_d;
  logic [15:0]                          part_q, part_d;
  logic [tge_pkg::CntBits-1:0]          cnt_q, cnt_d;

  logic signed [tge_pkg::VBits-1:0] vsum;
  logic signed [tge_pkg::VBits-1:0] vabs;
  logic [16:0]                      trial;
  logic [16:0]                      diff;
  logic                             ge;
  logic                             big_p;
  logic                             big_n;
  logic [16:0]                      remu;

  always_comb begin
    scl_d = scl_q;
    case (scl_q)
      tge_pkg::SCL_IDLE: if (req_i.start) scl_d = tge_pkg::SCL_MUL;
      tge_pkg::SCL_MUL:  scl_d = tge_pkg::SCL_ADD;
      tge_pkg::SCL_ADD:  scl_d = tge_pkg::SCL_DIV;
      tge_pkg::SCL_DIV:  if (cnt_q == '0) scl_d = tge_pkg::SCL_DONE;
      tge_pkg::SCL_DONE: scl_d = tge_pkg::SCL_IDLE;
      default:           scl_d = tge_pkg::SCL_IDLE;
    endcase
  end

  always_comb begin
    delta_d = delta_q;
    gain_d  = gain_q;
    div_d   = div_q;
    rin_d   = rin_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    part_d  = part_q;
    cnt_d   = cnt_q;
    vsum  = tge_pkg::VBits'(prod_q) + tge_pkg::VBits'(rin_q);
    vabs  = vsum[tge_pkg::VBits-1] ? -vsum : vsum;
    trial = {part_q, mag_q[tge_pkg::MagBits-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
    case (scl_q)
      tge_pkg::SCL_IDLE: begin
        if (req_i.start) begin
          delta_d = req_i.delta;
          gain_d  = req_i.gain;
          div_d   = (req_i.divisor == 16'd0) ? 16'd1 : req_i.divisor;
          rin_d   = req_i.rem;
        end
      end
      tge_pkg::SCL_MUL: begin
        prod_d = tge_pkg::ProdBits'(delta_q) * tge_pkg::ProdBits'($signed({1'b0, gain_q}));
      end
      tge_pkg::SCL_ADD: begin
        neg_d  = vsum[tge_pkg::VBits-1];
        mag_d  = vabs[tge_pkg::MagBits-1:0];
        part_d = '0;
        cnt_d  = tge_pkg::CntBits'(tge_pkg::MagBits - 1);
      end
      tge_pkg::SCL_DIV: begin
        part_d = ge ? diff[15:0] : trial[15:0];
        mag_d  = {mag_q[tge_pkg::MagBits-2:0], ge};
        cnt_d  = cnt_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Quotient saturates to 16 bits; the remainder takes the sign of the dividend.
  always_comb begin
    big_p = |mag_q[tge_pkg::MagBits-1:15];
    big_n = (|mag_q[tge_pkg::MagBits-1:16]) | (mag_q[15] & (|mag_q[14:0]));
    remu  = {1'b0, part_q};
    rsp_o.done = (scl_q == tge_pkg::SCL_DONE);
    if (neg_q) begin
      rsp_o.quot = big_n ? 16'sh8000 : $signed(16'(~mag_q[15:0] + 16'd1));
      rsp_o.rem  = $signed(17'(~remu + 17'd1));
    end else begin
      rsp_o.quot = big_p ? 16'sh7FFF : $signed(mag_q[15:0]);
      rsp_o.rem  = $signed(remu);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q <= tge_pkg::SCL_IDLE;
      cnt_q <= '0;
    end else begin
      scl_q <= scl_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    gain_q  <= gain_d;
    div_q   <= div_d;
    rin_q   <= rin_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    part_q  <= part_d;
  end

endmodule

// ----- sv/touch_gesture_engine.sv -----
// Flow: a tick or a frame without motion output goes from decode straight to its results;
// a frame with pointer or wheel motion runs the shared scaler twice before its first result.
// Throughput: one item at a time; the next is taken after the last result is taken.
// The scaler's 28-step serial divide is the long part of a motion frame.
// Reset (rst_ni low, asynchronous) restores control, config and gesture state; work registers are not reset.
module touch_gesture_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tge_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tge_pkg::out_t    out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int unsigned CB = tge_pkg::CoordBits;
  localparam int unsigned DB = tge_pkg::DeltaBits;
  localparam int unsigned RB = tge_pkg::RemBits;

  // Configuration registers.
  logic [15:0] gain_q, mdiv_q, wdiv_q, window_q, tslack_q, sslack_q, hold_q;
  logic        flip_q;

  // Gesture state.
  tge_pkg::mode_e       mode_q, mode_d;
  logic [CB-1:0]        prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [CB-1:0]        start_x_q, start_x_d, start_y_q, start_y_d;
  logic signed [RB-1:0] mrem_x_q, mrem_x_d, mrem_y_q, mrem_y_d;
  logic signed [RB-1:0] wrem_x_q, wrem_x_d, wrem_y_q, wrem_y_d;
  logic [31:0]          now_q, now_d, began_q, began_d;
  logic                 tap_q, tap_d, two_q, two_d, scrolling_q, scrolling_d;
  logic                 held_q, held_d, pressed_q, pressed_d;
  logic [15:0]          cd_q, cd_d;

  // Sequencer and work registers.
  tge_pkg::seq_e        state_q, state_d;
  tge_pkg::in_t         in_q, in_d;
  logic signed [DB-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                 wheel_q, wheel_d;
  logic signed [15:0]   rx_q, rx_d, ry_q, ry_d;
  tge_pkg::out_t        res_q [2];
  tge_pkg::out_t        res_d [2];
  logic                 res_idx_q, res_idx_d;

  logic [1:0]           n_c;
  logic                 scale_c;
  logic                 out_last;

  tge_pkg::scl_req_t    scl_req;
  tge_pkg::scl_rsp_t    scl_rsp;

  tge_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scl_req),
    .rsp_o  (scl_rsp)
  );

  function automatic tge_pkg::out_t mk_res(tge_pkg::evt_e code, logic btn,
                                           logic signed [15:0] value, logic sync,
                                           logic last);
    tge_pkg::out_t r;
    r.event_code  = code;
    r.button_id   = btn;
    r.event_value = value;
    r.sync_flag   = sync;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic logic [CB-1:0] mag_of(logic signed [DB-1:0] v);
    logic signed [DB-1:0] a;
    a = v[DB-1] ? -v : v;
    return a[CB-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == tge_pkg::SEQ_IDLE);
  assign out_valid_o = (state_q == tge_pkg::SEQ_EMIT);
  assign out_data_o  = res_q[res_idx_q];
  assign out_last    = res_q[res_idx_q].last_of_run;

  // The scaler runs the horizontal amount first, then the vertical one.
  always_comb begin
    scl_req.start   = (state_q == tge_pkg::SEQ_X_GO) || (state_q == tge_pkg::SEQ_Y_GO);
    scl_req.delta   = (state_q == tge_pkg::SEQ_X_GO) ? dx_q : dy_q;
    scl_req.gain    = wheel_q ? 16'd1 : gain_q;
    scl_req.divisor = wheel_q ? wdiv_q : mdiv_q;
    if (state_q == tge_pkg::SEQ_X_GO) begin
      scl_req.rem = wheel_q ? wrem_x_q : mrem_x_q;
    end else begin
      scl_req.rem = wheel_q ? wrem_y_q : mrem_y_q;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tge_pkg::SEQ_IDLE:   if (in_valid_i) state_d = tge_pkg::SEQ_DECODE;
      tge_pkg::SEQ_DECODE: begin
        if (scale_c) state_d = tge_pkg::SEQ_X_GO;
        else if (n_c != 2'd0) state_d = tge_pkg::SEQ_EMIT;
        else state_d = tge_pkg::SEQ_IDLE;
      end
      tge_pkg::SEQ_X_GO:   state_d = tge_pkg::SEQ_X_WAIT;
      tge_pkg::SEQ_X_WAIT: if (scl_rsp.done) state_d = tge_pkg::SEQ_Y_GO;
      tge_pkg::SEQ_Y_GO:   state_d = tge_pkg::SEQ_Y_WAIT;
      tge_pkg::SEQ_Y_WAIT: if (scl_rsp.done) state_d = tge_pkg::SEQ_PAIR;
      tge_pkg::SEQ_PAIR:   state_d = (n_c != 2'd0) ? tge_pkg::SEQ_EMIT : tge_pkg::SEQ_IDLE;
      tge_pkg::SEQ_EMIT:   if (out_ready_i && out_last) state_d = tge_pkg::SEQ_IDLE;
      default:             state_d = tge_pkg::SEQ_IDLE;
    endcase
  end

  // Datapath: decode of one item, motion capture and result assembly.
  always_comb begin
    logic [3:0]           cnt;
    logic                 v0, v1;
    logic [1:0]           nvalid;
    logic [CB-1:0]        px0, py0, px1, py1, cx, cy, tx, ty;
    logic [CB:0]          sx, sy;
    logic signed [DB-1:0] dpx, dpy, ox, oy;
    logic                 far_tap, far_scroll;
    logic [31:0]          elapsed;
    logic                 tap_ok;
    logic                 xnz, ynz;
    tge_pkg::evt_e        xcode, ycode;

    mode_d      = mode_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    mrem_x_d    = mrem_x_q;
    mrem_y_d    = mrem_y_q;
    wrem_x_d    = wrem_x_q;
    wrem_y_d    = wrem_y_q;
    now_d       = now_q;
    began_d     = began_q;
    tap_d       = tap_q;
    two_d       = two_q;
    scrolling_d = scrolling_q;
    held_d      = held_q;
    pressed_d   = pressed_q;
    cd_d        = cd_q;
    in_d        = in_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    wheel_d     = wheel_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    res_d[0]    = res_q[0];
    res_d[1]    = res_q[1];
    res_idx_d   = res_idx_q;
    n_c         = 2'd0;
    scale_c     = 1'b0;

    // Contact extraction: count clamps to two, an invalid id lets the next contact move up.
    cnt    = (in_q.raw_count > tge_pkg::MaxCount) ? tge_pkg::MaxCount : in_q.raw_count;
    v0     = (cnt >= 4'd1) && (in_q.first_id != tge_pkg::IdInvalid);
    v1     = (cnt >= 4'd2) && (in_q.second_id != tge_pkg::IdInvalid);
    nvalid = {1'b0, v0} + {1'b0, v1};
    px0    = v0 ? in_q.first_raw_y : in_q.second_raw_y;
    py0    = v0 ? in_q.first_raw_x : in_q.second_raw_x;
    px1    = in_q.second_raw_y;
    py1    = in_q.second_raw_x;
    sx     = {1'b0, px0} + {1'b0, px1};
    sy     = {1'b0, py0} + {1'b0, py1};
    cx     = sx[CB:1];
    cy     = sy[CB:1];
    tx     = (nvalid == 2'd2) ? cx : px0;
    ty     = (nvalid == 2'd2) ? cy : py0;
    dpx    = $signed({1'b0, tx}) - $signed({1'b0, prev_x_q});
    dpy    = $signed({1'b0, ty}) - $signed({1'b0, prev_y_q});
    ox     = $signed({1'b0, tx}) - $signed({1'b0, start_x_q});
    oy     = $signed({1'b0, ty}) - $signed({1'b0, start_y_q});
    far_tap    = ({4'd0, mag_of(ox)} > tslack_q) || ({4'd0, mag_of(oy)} > tslack_q);
    far_scroll = ({4'd0, mag_of(ox)} > sslack_q) || ({4'd0, mag_of(oy)} > sslack_q);
    elapsed    = now_q - began_q;
    tap_ok     = (mode_q != tge_pkg::MODE_IDLE) && tap_q && (elapsed <= {16'd0, window_q});

    xnz   = (rx_q != 16'sd0);
    ynz   = (ry_q != 16'sd0);
    xcode = wheel_q ? tge_pkg::EVT_HWHEEL : tge_pkg::EVT_MOVE_X;
    ycode = wheel_q ? tge_pkg::EVT_WHEEL : tge_pkg::EVT_MOVE_Y;

    case (state_q)
      tge_pkg::SEQ_IDLE: begin
        res_idx_d = 1'b0;
        if (in_valid_i) in_d = in_data_i;
      end
      tge_pkg::SEQ_DECODE: begin
        if (in_q.req_type) begin
          // Tick: advance time and count down a held tap click.
          now_d = now_q + 32'd1;
          if (pressed_q) begin
            if (cd_q == 16'd0) begin
              res_d[0]  = mk_res(tge_pkg::EVT_BUTTON, held_q, 16'sd0, 1'b1, 1'b1);
              n_c       = 2'd1;
              pressed_d = 1'b0;
            end else begin
              cd_d = cd_q - 16'd1;
            end
          end
        end else if (nvalid == 2'd0) begin
          // All fingers lifted: a short, still touch becomes a click.
          if (tap_ok) begin
            if (pressed_q) begin
              res_d[0] = mk_res(tge_pkg::EVT_BUTTON, held_q, 16'sd0, 1'b1, 1'b0);
              res_d[1] = mk_res(tge_pkg::EVT_BUTTON, two_q, 16'sd1, 1'b1, 1'b1);
              n_c      = 2'd2;
            end else begin
              res_d[0] = mk_res(tge_pkg::EVT_BUTTON, two_q, 16'sd1, 1'b1, 1'b1);
              n_c      = 2'd1;
            end
            held_d    = two_q;
            pressed_d = 1'b1;
            cd_d      = hold_q;
          end
          mode_d      = tge_pkg::MODE_IDLE;
          tap_d       = 1'b0;
          two_d       = 1'b0;
          scrolling_d = 1'b0;
          mrem_x_d    = '0;
          mrem_y_d    = '0;
          wrem_x_d    = '0;
          wrem_y_d    = '0;
        end else begin
          case (mode_q)
            tge_pkg::MODE_IDLE, tge_pkg::MODE_POINTER: begin
              if (mode_q == tge_pkg::MODE_POINTER && nvalid == 2'd1) begin
                prev_x_d = tx;
                prev_y_d = ty;
                if (far_tap) tap_d = 1'b0;
                dx_d    = flip_q ? -dpx : dpx;
                dy_d    = dpy;
                wheel_d = 1'b0;
                scale_c = 1'b1;
              end else if (nvalid == 2'd1) begin
                mode_d      = tge_pkg::MODE_POINTER;
                prev_x_d    = px0;
                prev_y_d    = py0;
                start_x_d   = px0;
                start_y_d   = py0;
                began_d     = now_q;
                tap_d       = 1'b1;
                two_d       = 1'b0;
                scrolling_d = 1'b0;
                mrem_x_d    = '0;
                mrem_y_d    = '0;
              end else begin
                // Second finger down: scrolling candidate. Only a fresh gesture restarts the tap timer.
                mode_d      = tge_pkg::MODE_SCROLL;
                prev_x_d    = cx;
                prev_y_d    = cy;
                start_x_d   = cx;
                start_y_d   = cy;
                if (mode_q == tge_pkg::MODE_IDLE) begin
                  began_d = now_q;
                  tap_d   = 1'b1;
                end
                two_d       = 1'b1;
                scrolling_d = 1'b0;
                wrem_x_d    = '0;
                wrem_y_d    = '0;
              end
            end
            tge_pkg::MODE_SCROLL: begin
              if (nvalid == 2'd2) begin
                prev_x_d = tx;
                prev_y_d = ty;
                if (!scrolling_q && far_scroll) begin
                  scrolling_d = 1'b1;
                  tap_d       = 1'b0;
                end
                if (scrolling_q || far_scroll) begin
                  dx_d    = flip_q ? -dpx : dpx;
                  dy_d    = -dpy;
                  wheel_d = 1'b1;
                  scale_c = 1'b1;
                end
              end else begin
                mode_d = tge_pkg::MODE_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tge_pkg::SEQ_X_WAIT: begin
        if (scl_rsp.done) begin
          rx_d = scl_rsp.quot;
          if (wheel_q) wrem_x_d = scl_rsp.rem;
          else mrem_x_d = scl_rsp.rem;
        end
      end
      tge_pkg::SEQ_Y_WAIT: begin
        if (scl_rsp.done) begin
          ry_d = scl_rsp.quot;
          if (wheel_q) wrem_y_d = scl_rsp.rem;
          else mrem_y_d = scl_rsp.rem;
        end
      end
      tge_pkg::SEQ_PAIR: begin
        // Nonzero amounts only; the last one closes the report group.
        if (xnz && ynz) begin
          res_d[0] = mk_res(xcode, 1'b0, rx_q, 1'b0, 1'b0);
          res_d[1] = mk_res(ycode, 1'b0, ry_q, 1'b1, 1'b1);
          n_c      = 2'd2;
        end else if (xnz) begin
          res_d[0] = mk_res(xcode, 1'b0, rx_q, 1'b1, 1'b1);
          n_c      = 2'd1;
        end else if (ynz) begin
          res_d[0] = mk_res(ycode, 1'b0, ry_q, 1'b1, 1'b1);
          n_c      = 2'd1;
        end
      end
      tge_pkg::SEQ_EMIT: begin
        if (out_ready_i) res_idx_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 16'd1;
      mdiv_q   <= 16'd1;
      wdiv_q   <= 16'd8;
      window_q <= 16'd200;
      tslack_q <= 16'd30;
      sslack_q <= 16'd30;
      hold_q   <= 16'd20;
      flip_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        tge_pkg::CFG_MOVE_GAIN:    gain_q   <= cfg_data_i;
        tge_pkg::CFG_MOVE_DIVIDE:  mdiv_q   <= cfg_data_i;
        tge_pkg::CFG_WHEEL_DIVIDE: wdiv_q   <= cfg_data_i;
        tge_pkg::CFG_TAP_WINDOW:   window_q <= cfg_data_i;
        tge_pkg::CFG_TAP_SLACK:    tslack_q <= cfg_data_i;
        tge_pkg::CFG_SCROLL_SLACK: sslack_q <= cfg_data_i;
        tge_pkg::CFG_CLICK_HOLD:   hold_q   <= cfg_data_i;
        tge_pkg::CFG_FLIP_X:       flip_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tge_pkg::SEQ_IDLE;
      res_idx_q   <= 1'b0;
      mode_q      <= tge_pkg::MODE_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      mrem_x_q    <= '0;
      mrem_y_q    <= '0;
      wrem_x_q    <= '0;
      wrem_y_q    <= '0;
      now_q       <= '0;
      began_q     <= '0;
      tap_q       <= 1'b0;
      two_q       <= 1'b0;
      scrolling_q <= 1'b0;
      held_q      <= 1'b0;
      pressed_q   <= 1'b0;
      cd_q        <= '0;
    end else begin
      state_q     <= state_d;
      res_idx_q   <= res_idx_d;
      mode_q      <= mode_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      start_x_q   <= start_x_d;
      start_y_q   <= start_y_d;
      mrem_x_q    <= mrem_x_d;
      mrem_y_q    <= mrem_y_d;
      wrem_x_q    <= wrem_x_d;
      wrem_y_q    <= wrem_y_d;
      now_q       <= now_d;
      began_q     <= began_d;
      tap_q       <= tap_d;
      two_q       <= two_d;
      scrolling_q <= scrolling_d;
      held_q      <= held_d;
      pressed_q   <= pressed_d;
      cd_q        <= cd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    wheel_q  <= wheel_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    res_q[0] <= res_d[0];
    res_q[1] <= res_d[1];
  end

  // The scaler only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_rsp.done |-> (state_q == tge_pkg::SEQ_X_WAIT || state_q == tge_pkg::SEQ_Y_WAIT))
    else $error("scaler finished outside a wait state");

  // A press shown on the output always matches a held button.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.event_code == tge_pkg::EVT_BUTTON &&
     out_data_o.event_value == 16'sd1) |-> pressed_q)
    else $error("button press without held button");

  // Scrolling is only ever set inside a two-finger gesture.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scrolling_q |-> (mode_q == tge_pkg::MODE_SCROLL || mode_q == tge_pkg::MODE_WAIT))
    else $error("scrolling flag outside scroll mode");

  // A motion frame always goes through the scaler before its results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tge_pkg::SEQ_PAIR) |-> $past(scl_rsp.done))
    else $error("result assembly without a finished scale");

endmodule

// ----- tb/tb_touch_gesture_engine.sv -----
// Self-checking testbench for the touch gesture engine.
// Holds a scoreboard class with its own gesture predictor; depends on tge_pkg and the block.
`timescale 1ns / 1ps

class tge_scoreboard;
  tge_pkg::out_t expected_q[$];
  int errors;
  int frames_seen;
  int ticks_seen;
  int events_checked;

  // Register copies.
  int unsigned gain, move_div, wheel_div, tap_win, tap_slack, scroll_slack, hold_ms;
  bit flip;

  // Gesture state.
  tge_pkg::mode_e mode;
  int prev_x, prev_y, start_x, start_y;
  int mrem_x, mrem_y, wrem_x, wrem_y;
  int unsigned now_ms, began_ms;
  bit tap_ok, two_seen, scrolling, held_btn, pressed;
  logic [15:0] countdown;

  function new();
    gain = 1; move_div = 1; wheel_div = 8; tap_win = 200;
    tap_slack = 30; scroll_slack = 30; hold_ms = 20; flip = 0;
    mode = tge_pkg::MODE_IDLE;
    prev_x = 0; prev_y = 0; start_x = 0; start_y = 0;
    mrem_x = 0; mrem_y = 0; wrem_x = 0; wrem_y = 0;
    now_ms = 0; began_ms = 0;
    tap_ok = 0; two_seen = 0; scrolling = 0; held_btn = 0; pressed = 0;
    countdown = '0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void write_reg(tge_pkg::cfg_e idx, logic [15:0] d);
    case (idx)
      tge_pkg::CFG_MOVE_GAIN:    gain = d;
      tge_pkg::CFG_MOVE_DIVIDE:  move_div = d;
      tge_pkg::CFG_WHEEL_DIVIDE: wheel_div = d;
      tge_pkg::CFG_TAP_WINDOW:   tap_win = d;
      tge_pkg::CFG_TAP_SLACK:    tap_slack = d;
      tge_pkg::CFG_SCROLL_SLACK: scroll_slack = d;
      tge_pkg::CFG_CLICK_HOLD:   hold_ms = d;
      default:                   flip = d[0];
    endcase
  endfunction

  function void push_evt(tge_pkg::evt_e code, bit btn, int value, bit sync);
    tge_pkg::out_t o;
    o.event_code  = code;
    o.button_id   = btn;
    o.event_value = value[15:0];
    o.sync_flag   = sync;
    o.last_of_run = 1'b0;
    expected_q.push_back(o);
  endfunction

  // Scales a delta with a carried remainder; a zero divisor counts as one.
  function int scaled_amount(int delta, int unsigned g, int unsigned dv, ref int rem);
    int d, v, q;
    d = (dv == 0) ? 1 : int'(dv);
    v = delta * int'(g) + rem;
    q = v / d;
    rem = v - q * d;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function void report_pair(tge_pkg::evt_e xc, int x, tge_pkg::evt_e yc, int y);
    if (x != 0 && y != 0) begin
      push_evt(xc, 0, x, 0);
      push_evt(yc, 0, y, 1);
    end else if (x != 0) begin
      push_evt(xc, 0, x, 1);
    end else if (y != 0) begin
      push_evt(yc, 0, y, 1);
    end
  endfunction

  function void begin_scroll(int cx, int cy, bit fresh);
    mode = tge_pkg::MODE_SCROLL;
    prev_x = cx; start_x = cx;
    prev_y = cy; start_y = cy;
    if (fresh) begin
      began_ms = now_ms;
      tap_ok = 1;
    end
    two_seen = 1;
    scrolling = 0;
    wrem_x = 0; wrem_y = 0;
  endfunction

  function int absv(int v);
    return (v < 0) ? -v : v;
  endfunction

  function void note_input(tge_pkg::in_t it);
    int n0, cnt, nvalid, px[2], py[2], cx, cy, dx, dy, rx, ry;
    logic [3:0] id;
    n0 = expected_q.size();
    nvalid = 0;
    if (it.req_type) begin
      ticks_seen++;
      now_ms++;
      if (pressed) begin
        if (countdown == 0) begin
          push_evt(tge_pkg::EVT_BUTTON, held_btn, 0, 1);
          pressed = 0;
        end else begin
          countdown--;
        end
      end
    end else begin
      frames_seen++;
      cnt = (it.raw_count > 2) ? 2 : int'(it.raw_count);
      for (int i = 0; i < cnt; i++) begin
        id = (i == 0) ? it.first_id : it.second_id;
        if (id != tge_pkg::IdInvalid) begin
          py[nvalid] = (i == 0) ? it.first_raw_x : it.second_raw_x;
          px[nvalid] = (i == 0) ? it.first_raw_y : it.second_raw_y;
          nvalid++;
        end
      end
      if (nvalid == 0) begin
        // Lift: a short, still gesture becomes a click.
        if (mode != tge_pkg::MODE_IDLE && tap_ok && (now_ms - began_ms) <= tap_win) begin
          if (pressed) push_evt(tge_pkg::EVT_BUTTON, held_btn, 0, 1);
          held_btn = two_seen;
          pressed = 1;
          push_evt(tge_pkg::EVT_BUTTON, two_seen, 1, 1);
          countdown = hold_ms[15:0];
        end
        mode = tge_pkg::MODE_IDLE;
        tap_ok = 0; two_seen = 0; scrolling = 0;
        mrem_x = 0; mrem_y = 0; wrem_x = 0; wrem_y = 0;
      end else begin
        cx = (px[0] + ((nvalid == 2) ? px[1] : 0)) / 2;
        cy = (py[0] + ((nvalid == 2) ? py[1] : 0)) / 2;
        case (mode)
          tge_pkg::MODE_IDLE: begin
            if (nvalid == 1) begin
              mode = tge_pkg::MODE_POINTER;
              prev_x = px[0]; start_x = px[0];
              prev_y = py[0]; start_y = py[0];
              began_ms = now_ms;
              tap_ok = 1; two_seen = 0; scrolling = 0;
              mrem_x = 0; mrem_y = 0;
            end else begin
              begin_scroll(cx, cy, 1);
            end
          end
          tge_pkg::MODE_POINTER: begin
            if (nvalid == 1) begin
              dx = px[0] - prev_x;
              dy = py[0] - prev_y;
              prev_x = px[0]; prev_y = py[0];
              if (absv(px[0] - start_x) > int'(tap_slack) ||
                  absv(py[0] - start_y) > int'(tap_slack)) tap_ok = 0;
              if (flip) dx = -dx;
              rx = scaled_amount(dx, gain, move_div, mrem_x);
              ry = scaled_amount(dy, gain, move_div, mrem_y);
              report_pair(tge_pkg::EVT_MOVE_X, rx, tge_pkg::EVT_MOVE_Y, ry);
            end else begin
              begin_scroll(cx, cy, 0);
            end
          end
          tge_pkg::MODE_SCROLL: begin
            if (nvalid == 2) begin
              dx = cx - prev_x;
              dy = cy - prev_y;
              prev_x = cx; prev_y = cy;
              if (!scrolling && (absv(cx - start_x) > int'(scroll_slack) ||
                                 absv(cy - start_y) > int'(scroll_slack))) begin
                scrolling = 1;
                tap_ok = 0;
              end
              if (scrolling) begin
                if (flip) dx = -dx;
                rx = scaled_amount(dx, 1, wheel_div, wrem_x);
                ry = scaled_amount(-dy, 1, wheel_div, wrem_y);
                report_pair(tge_pkg::EVT_HWHEEL, rx, tge_pkg::EVT_WHEEL, ry);
              end
            end else begin
              mode = tge_pkg::MODE_WAIT;
            end
          end
          default: ;
        endcase
      end
    end
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last_of_run = 1'b1;
  endfunction

  function void check_result(tge_pkg::out_t got);
    tge_pkg::out_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected event: code %0d value %0d", got.event_code, got.event_value);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    events_checked++;
    if (got.event_code !== want.event_code) begin
      $error("event_code expected %0d got %0d", want.event_code, got.event_code);
      errors++;
    end
    if (got.button_id !== want.button_id) begin
      $error("button_id expected %0d got %0d", want.button_id, got.button_id);
      errors++;
    end
    if (got.event_value !== want.event_value) begin
      $error("event_value expected %0d got %0d", want.event_value, got.event_value);
      errors++;
    end
    if (got.sync_flag !== want.sync_flag) begin
      $error("sync_flag expected %0d got %0d", want.sync_flag, got.sync_flag);
      errors++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run expected %0d got %0d", want.last_of_run, got.last_of_run);
      errors++;
    end
  endfunction
endclass

module tb_touch_gesture_engine;

  localparam int ItemsTarget = 700;
  localparam int WatchLimit  = 20000;
  localparam int SettleCycles = 120;  // long enough for a motion frame with no output to finish

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  tge_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  tge_pkg::out_t out_data_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [2:0]    cfg_idx_i;
  logic [15:0]   cfg_data_i;

  touch_gesture_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  tge_scoreboard gestures = new();

  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;
  bit stall_kick;
  int quiet_cycles;
  int cur_x, cur_y, cur_x2, cur_y2;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Receiver: checks each accepted event, then decides ready for the next edge.
  // A requested long hold-off is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) gestures.check_result(out_data_o);
    if (stall_kick) begin
      stall_kick = 1'b0;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any cycle with a handshake on any channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp12(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  function automatic tge_pkg::in_t frame_item(int cnt, int id0, int x0, int y0, int id1,
                                              int x1, int y1);
    tge_pkg::in_t it;
    it.req_type     = 1'b0;
    it.raw_count    = cnt[3:0];
    it.first_id     = id0[3:0];
    it.first_raw_x  = x0[11:0];
    it.first_raw_y  = y0[11:0];
    it.second_id    = id1[3:0];
    it.second_raw_x = x1[11:0];
    it.second_raw_y = y1[11:0];
    return it;
  endfunction

  // Fully random item; the tick flag is chosen by the caller.
  function automatic tge_pkg::in_t noise_item(bit is_tick);
    tge_pkg::in_t it;
    it = frame_item($urandom_range(15), $urandom_range(15), $urandom_range(4095),
                    $urandom_range(4095), $urandom_range(15), $urandom_range(4095),
                    $urandom_range(4095));
    it.req_type = is_tick;
    return it;
  endfunction

  // Offers one item and returns at the edge where it is taken; valid stays high after.
  task automatic send_item(tge_pkg::in_t it);
    int gap;
    case (items_sent * 3 / ItemsTarget)
      0:       begin send_idle_pct = 31; recv_idle_pct = 52; end
      1:       begin send_idle_pct = 52; recv_idle_pct = 31; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    gestures.note_input(it);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(noise_item(1'b1));
  endtask

  // Stops offering items and lets every expected event and any silent work finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (gestures.pending() > 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(tge_pkg::cfg_e idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    gestures.write_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_regs(int g, int md, int wd, int tw, int ts, int ss, int ch, int fx);
    write_reg(tge_pkg::CFG_MOVE_GAIN, g[15:0]);
    write_reg(tge_pkg::CFG_MOVE_DIVIDE, md[15:0]);
    write_reg(tge_pkg::CFG_WHEEL_DIVIDE, wd[15:0]);
    write_reg(tge_pkg::CFG_TAP_WINDOW, tw[15:0]);
    write_reg(tge_pkg::CFG_TAP_SLACK, ts[15:0]);
    write_reg(tge_pkg::CFG_SCROLL_SLACK, ss[15:0]);
    write_reg(tge_pkg::CFG_CLICK_HOLD, ch[15:0]);
    write_reg(tge_pkg::CFG_FLIP_X, fx[15:0]);
  endtask

  // One random gesture: a touch-down, a walk of frames with ticks mixed in, then a lift.
  // A tenth of the calls send pure noise instead.
  task automatic random_gesture();
    int kind, fingers, nframes, step, lift;
    kind = $urandom_range(9);
    if (kind == 0) begin
      send_item(noise_item($urandom_range(1)));
      return;
    end
    fingers = (kind < 5) ? 1 : 2;
    nframes = $urandom_range(1, 8);
    step = kind[0] ? 5 : 300;
    cur_x = $urandom_range(4095); cur_y = $urandom_range(4095);
    cur_x2 = $urandom_range(4095); cur_y2 = $urandom_range(4095);
    for (int f = 0; f < nframes; f++) begin
      if ($urandom_range(7) == 0) fingers = 3 - fingers;
      if (fingers == 1) begin
        if ($urandom_range(4) == 0)
          // Invalid first contact, so the second one moves up.
          send_item(frame_item(2, tge_pkg::IdInvalid, $urandom_range(4095),
                               $urandom_range(4095), $urandom_range(14), cur_x, cur_y));
        else
          send_item(frame_item($urandom_range(4) == 0 ? 1 : $urandom_range(1, 15),
                               $urandom_range(14), cur_x, cur_y,
                               $urandom_range(3) == 0 ? $urandom_range(14) : tge_pkg::IdInvalid,
                               cur_x2, cur_y2));
      end else begin
        send_item(frame_item($urandom_range(2, 15), $urandom_range(14), cur_x, cur_y,
                             $urandom_range(14), cur_x2, cur_y2));
      end
      cur_x  = clamp12(cur_x + $urandom_range(2 * step) - step);
      cur_y  = clamp12(cur_y + $urandom_range(2 * step) - step);
      cur_x2 = clamp12(cur_x2 + $urandom_range(2 * step) - step);
      cur_y2 = clamp12(cur_y2 + $urandom_range(2 * step) - step);
      if ($urandom_range(2) == 0) send_ticks($urandom_range(1, 3));
    end
    lift = $urandom_range(2);
    if (lift == 0)
      send_item(frame_item(0, $urandom_range(15), $urandom_range(4095), $urandom_range(4095),
                           $urandom_range(15), $urandom_range(4095), $urandom_range(4095)));
    else
      send_item(frame_item(lift == 1 ? $urandom_range(1, 15) : 2, tge_pkg::IdInvalid,
                           $urandom_range(4095), $urandom_range(4095), tge_pkg::IdInvalid,
                           $urandom_range(4095), $urandom_range(4095)));
    if ($urandom_range(3) == 0) send_ticks($urandom_range(1, 25));
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_idx_i    = tge_pkg::CFG_MOVE_GAIN;
    cfg_data_i   = '0;
    items_sent   = 0;
    stall_left   = 0;
    stall_kick   = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings.
    // One-finger tap, then hold the click until the countdown runs out.
    send_item(frame_item(1, 0, 100, 200, 0, 0, 0));
    send_ticks(2);
    send_item(frame_item(0, 0, 0, 0, 0, 0, 0));
    send_ticks(22);
    // Pointer motion at the coordinate extremes with a count above two.
    send_item(frame_item(15, 3, 0, 0, tge_pkg::IdInvalid, 4095, 4095));
    send_item(frame_item(15, 3, 4095, 4095, tge_pkg::IdInvalid, 0, 0));
    send_item(frame_item(1, 3, 4095, 0, 0, 0, 0));
    // Second finger turns it into a scroll, which then crosses the threshold.
    send_item(frame_item(2, 1, 0, 0, 2, 4095, 4095));
    send_item(frame_item(2, 1, 100, 0, 2, 4095, 3000));
    send_item(frame_item(2, 1, 4095, 4095, 2, 4095, 4095));
    // One finger left: wait for release, contacts are ignored.
    send_item(frame_item(1, 1, 500, 500, 0, 0, 0));
    send_item(frame_item(2, 1, 900, 900, 2, 10, 10));
    send_item(frame_item(0, tge_pkg::IdInvalid, 0, 0, tge_pkg::IdInvalid, 0, 0));
    // Two-finger tap gives a right click; a second tap clicks while still pressed.
    send_item(frame_item(2, 4, 800, 800, 5, 820, 820));
    send_item(frame_item(2, tge_pkg::IdInvalid, 0, 0, tge_pkg::IdInvalid, 0, 0));
    send_item(frame_item(1, 14, 50, 50, 0, 0, 0));
    send_item(frame_item(3, tge_pkg::IdInvalid, 1, 1, tge_pkg::IdInvalid, 2, 2));
    drain();

    // Phases of settings; each ends idle before its registers change.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_regs(1, 1, 8, 200, 30, 30, 20, 0);
        1: load_regs(65535, 1, 1, 0, 0, 0, 0, 1);
        2: load_regs(3, 7, 65535, 65535, 65535, 65535, 65535, 0);
        3: load_regs(0, 0, 0, $urandom_range(300), $urandom_range(50), $urandom_range(50),
                     $urandom_range(5), 1);
        default: load_regs($urandom_range(65535), $urandom_range(1, 65535),
                           $urandom_range(1, 64), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(30), $urandom_range(1));
      endcase
      if (phase == 1) stall_kick = 1'b1;
      while (items_sent < 25 + (phase + 1) * (ItemsTarget - 25) / 5) random_gesture();
      drain();
    end

    $display("Covered %0d frames and %0d ticks, %0d events checked, over five register sets.",
             gestures.frames_seen, gestures.ticks_seen, gestures.events_checked);
    if (gestures.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
